// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks; only the top level uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge while out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lfcr_pkg.sv =====
// Shared types and constants for the length-prefixed frame CRC receiver.
`timescale 1ns / 1ps

package lfcr_pkg;

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcXorOut = 32'hFFFF_FFFF;

  // Frame status codes reported with every result beat
  localparam logic [1:0] FsProgress = 2'd0;
  localparam logic [1:0] FsMatch    = 2'd1;
  localparam logic [1:0] FsMismatch = 2'd2;
  localparam logic [1:0] FsIgnored  = 2'd3;

  typedef enum logic [6:0] {
    PH_LEN_HI = 7'b000_0001,
    PH_LEN_LO = 7'b000_0010,
    PH_STATUS = 7'b000_0100,
    PH_DATA   = 7'b000_1000,
    PH_CRC    = 7'b001_0000,
    PH_DONE   = 7'b010_0000,
    PH_ERROR  = 7'b100_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } lfcr_in_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [15:0] data_index;
    logic [1:0]  frame_status;
    logic [7:0]  status_byte;
    logic [15:0] frame_length;
  } lfcr_out_t;

endpackage

// ===== hw/rtl/lfcr_crc_byte.sv =====
// Byte-wide update of the reflected CRC-32.
`timescale 1ns / 1ps

module lfcr_crc_byte import lfcr_pkg::*; (
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] acc;
    acc = crc_i ^ {24'd0, byte_i};
    for (int i = 0; i < 8; i++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_o = acc;
  end

endmodule

// ===== hw/rtl/lfcr_in_stage.sv =====
// Input register stage: holds one accepted beat until the parser takes it.
`timescale 1ns / 1ps

module lfcr_in_stage import lfcr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lfcr_in_t in_data_i,
  input  logic     advance_i,
  output logic     valid_o,
  output lfcr_in_t data_o
);

  logic     valid_d, valid_q;
  lfcr_in_t data_d, data_q;
  logic     fire;

  // Take a new beat when empty or when the held one moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (fire) begin
      valid_d = 1'b1;
      data_d  = in_data_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/lfcr_parser.sv =====
// Frame parser: header, data and CRC phases with the running CRC-32 check.
`timescale 1ns / 1ps

module lfcr_parser import lfcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  lfcr_in_t  item_i,
  output lfcr_out_t result_o
);

  phase_e      phase_d, phase_q;
  logic [7:0]  length_high_d, length_high_q;
  logic [15:0] data_length_d, data_length_q;
  logic [15:0] byte_count_d, byte_count_q;
  logic [7:0]  status_byte_d, status_byte_q;
  logic [31:0] running_crc_d, running_crc_q;
  logic [31:0] received_crc_d, received_crc_q;
  logic [1:0]  crc_cnt_d, crc_cnt_q;
  logic [31:0] crc_next;
  logic [31:0] crc_lane;

  lfcr_crc_byte u_crc (
    .crc_i  (running_crc_q),
    .byte_i (item_i.rx_byte),
    .crc_o  (crc_next)
  );

  // Place the received CRC byte in its lane, low byte first
  always_comb begin
    unique case (crc_cnt_q)
      2'd0:    crc_lane = {24'd0, item_i.rx_byte};
      2'd1:    crc_lane = {16'd0, item_i.rx_byte, 8'd0};
      2'd2:    crc_lane = {8'd0, item_i.rx_byte, 16'd0};
      default: crc_lane = {item_i.rx_byte, 24'd0};
    endcase
  end

  always_comb begin
    phase_d        = phase_q;
    length_high_d  = length_high_q;
    data_length_d  = data_length_q;
    byte_count_d   = byte_count_q;
    status_byte_d  = status_byte_q;
    running_crc_d  = running_crc_q;
    received_crc_d = received_crc_q;
    crc_cnt_d      = crc_cnt_q;

    result_o              = '0;
    result_o.frame_status = FsProgress;

    if (item_i.restart) begin
      phase_d               = PH_LEN_HI;
      length_high_d         = 8'd0;
      data_length_d         = 16'd0;
      byte_count_d          = 16'd0;
      status_byte_d         = 8'd0;
      running_crc_d         = CrcInit;
      received_crc_d        = 32'd0;
      crc_cnt_d             = 2'd0;
      result_o.frame_status = FsIgnored;
    end else begin
      unique case (phase_q)
        PH_LEN_HI: begin
          length_high_d = item_i.rx_byte;
          phase_d       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          data_length_d = {length_high_q, item_i.rx_byte};
          phase_d       = PH_STATUS;
        end
        PH_STATUS: begin
          status_byte_d = item_i.rx_byte;
          // An empty frame goes straight to the CRC bytes
          phase_d = (data_length_q == 16'd0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          result_o.data_valid = 1'b1;
          result_o.data_byte  = item_i.rx_byte;
          result_o.data_index = byte_count_q;
          running_crc_d       = crc_next;
          byte_count_d        = byte_count_q + 16'd1;
          if (byte_count_d == data_length_q) begin
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          received_crc_d = received_crc_q | crc_lane;
          if (crc_cnt_q == 2'd3) begin
            crc_cnt_d = 2'd0;
            if ((running_crc_q ^ CrcXorOut) == received_crc_d) begin
              phase_d               = PH_DONE;
              result_o.frame_status = FsMatch;
            end else begin
              phase_d               = PH_ERROR;
              result_o.frame_status = FsMismatch;
            end
          end else begin
            crc_cnt_d = crc_cnt_q + 2'd1;
          end
        end
        default: begin
          // Frame finished: drop the byte until restart
          result_o.frame_status = FsIgnored;
        end
      endcase
    end

    result_o.status_byte  = status_byte_d;
    result_o.frame_length = data_length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_LEN_HI;
      length_high_q  <= 8'd0;
      data_length_q  <= 16'd0;
      byte_count_q   <= 16'd0;
      status_byte_q  <= 8'd0;
      running_crc_q  <= CrcInit;
      received_crc_q <= 32'd0;
      crc_cnt_q      <= 2'd0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      length_high_q  <= length_high_d;
      data_length_q  <= data_length_d;
      byte_count_q   <= byte_count_d;
      status_byte_q  <= status_byte_d;
      running_crc_q  <= running_crc_d;
      received_crc_q <= received_crc_d;
      crc_cnt_q      <= crc_cnt_d;
    end
  end

endmodule

// ===== hw/rtl/length_prefixed_frame_crc_receiver.sv =====
// Top level of the length-prefixed frame receiver with CRC-32 check.
// Path: a beat accepted into the input register passes the parser into the result
// register and leaves it by the output handshake. Throughput: one byte per cycle
// while out_ready_i takes results, set by the input and the output register.
// The parser, CRC update and result register advance together in a single step.
// Reset: asynchronous, active low; clears both stages and returns the parser to
// awaiting the length high byte with the CRC at all ones.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module length_prefixed_frame_crc_receiver import lfcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lfcr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lfcr_out_t out_data_o
);

  logic      item_valid;
  lfcr_in_t  item;
  logic      advance;
  lfcr_out_t result;
  logic      out_valid_d, out_valid_q;
  lfcr_out_t out_data_d, out_data_q;

  // Move a held beat on when the result register is free or being emptied
  assign advance = item_valid && (!out_valid_q || out_ready_i);

  lfcr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  lfcr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_IMPLIES(a_data_in_progress, clk_i, rst_ni,
                  out_valid_o && out_data_o.data_valid,
                  out_data_o.frame_status == FsProgress,
                  "data beat reported with a final frame status")
  `ASSERT_IMPLIES(a_data_nonempty, clk_i, rst_ni,
                  out_valid_o && out_data_o.data_valid,
                  out_data_o.frame_length != 16'd0,
                  "data beat reported in an empty frame")
  `ASSERT_NEXT(a_held_beat_kept, clk_i, rst_ni,
               item_valid && !advance,
               item_valid,
               "held input beat lost while stalled")
  `ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni,
               advance,
               out_valid_o,
               "processed beat did not reach the result register")

endmodule
